// File: hdl/time_window_rolling_median_core_defines.svh
// Assertion macros used by the core design file.
`ifndef TIME_WINDOW_ROLLING_MEDIAN_CORE_DEFINES_SVH
`define TIME_WINDOW_ROLLING_MEDIAN_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TWRM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TWRM_ASSERT(label, prop, msg) \
  `TWRM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define TWRM_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define TWRM_ASSERT(label, prop, msg)
`endif
`endif

// File: hdl/twrm_pkg.sv
package twrm_pkg;

  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REACH_BACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACH_AHEAD = 2'd1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_START,
    CELL_RANK,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] stored;
    logic [CNT_W-1:0] wr_pos;
  } cell_ctrl_t;

endpackage

// File: hdl/twrm_cell.sv
module twrm_cell import twrm_pkg::*; #(
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 6,
  parameter int CELL_POS   = 0
) (
  input  logic                         clk_i,
  input  cell_ctrl_t                   ctrl_i,
  input  logic        [TIME_BITS-1:0]  pend_time_i,
  input  logic        [CFG_W-1:0]      reach_back_i,
  input  logic        [CFG_W-1:0]      reach_ahead_i,
  input  logic        [TIME_BITS-1:0]  nb_time_i,
  input  logic signed [VALUE_BITS-1:0] nb_value_i,
  input  logic        [IDX_W-1:0]      nb_idx_i,
  input  logic        [CNT_W-1:0]      nb_rank_i,
  input  logic signed [VALUE_BITS-1:0] head_value_i,
  input  logic        [IDX_W-1:0]      head_idx_i,
  input  logic                         head_in_i,
  input  logic        [TIME_BITS-1:0]  new_time_i,
  input  logic signed [VALUE_BITS-1:0] new_value_i,
  output logic        [TIME_BITS-1:0]  time_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic        [IDX_W-1:0]      idx_o,
  output logic        [CNT_W-1:0]      rank_o,
  output logic        [CNT_W-1:0]      rank_fwd_o,
  output logic                         in_win_o
);

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic        [TIME_BITS-1:0]  time_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic        [IDX_W-1:0]      idx_q;
  logic        [CNT_W-1:0]      rank_q;
  logic                         above_low;
  logic                         below_high;
  logic                         occupied;
  logic                         less;

  always_comb begin
    above_low  = (time_q > pend_time_i) ||
                 (CMP_W'(pend_time_i - time_q) < CMP_W'(reach_back_i));
    below_high = (time_q <= pend_time_i) ||
                 (CMP_W'(time_q - pend_time_i) <= CMP_W'(reach_ahead_i));
    occupied   = CNT_W'(idx_q) < ctrl_i.stored;
    in_win_o   = occupied && above_low && below_high;
    less       = head_in_i && in_win_o &&
                 ((head_value_i < value_q) ||
                  ((head_value_i == value_q) && (head_idx_i < idx_q)));
    rank_fwd_o = (ctrl_i.op == CELL_RANK) ? rank_q + CNT_W'(less) : rank_q;
  end

  assign time_o  = time_q;
  assign value_o = value_q;
  assign idx_o   = idx_q;
  assign rank_o  = rank_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_START: begin
        idx_q  <= IDX_W'(CELL_POS);
        rank_q <= '0;
      end
      CELL_RANK, CELL_ROTATE, CELL_SHIFT: begin
        time_q  <= nb_time_i;
        value_q <= nb_value_i;
        idx_q   <= nb_idx_i;
        rank_q  <= nb_rank_i;
      end
      CELL_WRITE: begin
        if (ctrl_i.wr_pos == CNT_W'(CELL_POS)) begin
          time_q  <= new_time_i;
          value_q <= new_value_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/time_window_rolling_median_core.sv
// Rolling median over a time window, built as a ring of entry cells.
// Input channel: in_valid_i / in_stall_o with obs_time_i, obs_value_i and
// end_of_series_i; a transfer happens when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with one result per transfer.
// Configuration: cfg_valid_i / cfg_ready_o write the backward reach (index 0)
// or the forward reach (index 1); writes are taken in any cycle.
// One item is worked on at a time. For every median, one full turn of the
// cell ring ranks the window entries and a second turn picks the two middle
// values.
// A result is held back until the next one of the same item exists, so that
// the last one can carry last_in_run; results leave through an output
// register, and while the receiver stalls the core keeps working until that
// register and the holding stage are both full.
// Reset empties the buffer and the pending list, sets the backward reach to 1
// and the forward reach to 0. The stored entries need no clearing.
`include "time_window_rolling_median_core_defines.svh"

module time_window_rolling_median_core import twrm_pkg::*; #(
  parameter int BUFFER_DEPTH = 64,
  parameter int VALUE_BITS   = 32,
  parameter int TIME_BITS    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_W-1:0]      cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic        [TIME_BITS-1:0]  obs_time_i,
  input  logic signed [VALUE_BITS-1:0] obs_value_i,
  input  logic                         end_of_series_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic        [TIME_BITS-1:0]  result_time_o,
  output logic signed [VALUE_BITS-1:0] median_value_o,
  output logic        [CNT_W-1:0]      window_count_o,
  output logic                         empty_window_o,
  output logic                         truncated_o,
  output logic                         order_error_o,
  output logic                         last_in_run_o
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RETIRE, S_DROP, S_WRITE, S_AFTER, S_FLUSH,
    S_START, S_PASS1, S_PASS2, S_EMIT, S_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]  rtime;
    logic [VALUE_BITS-1:0] med;
    logic [CNT_W-1:0]      cnt;
    logic                  empty;
    logic                  trunc;
    logic                  oerr;
  } result_t;

  state_e                       state_q, ret_q;
  logic        [CFG_W-1:0]      wb_q, wa_q;
  logic        [TIME_BITS-1:0]  in_time_q;
  logic signed [VALUE_BITS-1:0] in_value_q;
  logic                         in_eos_q;
  logic        [CNT_W-1:0]      stored_q, pend_q, win_cnt_q;
  logic        [TIME_BITS-1:0]  prev_time_q, horizon_q, pend_time_q, next_pt_q;
  logic                         seen_q, ovf_q, force_q;
  logic        [IDX_W-1:0]      step_q;
  logic signed [VALUE_BITS-1:0] lo_q, hi_q;
  result_t                      held_q, out_q;
  logic                         held_v_q, out_v_q, out_last_q;

  cell_ctrl_t                   ctrl;
  logic        [TIME_BITS-1:0]  c_time  [BUFFER_DEPTH];
  logic signed [VALUE_BITS-1:0] c_value [BUFFER_DEPTH];
  logic        [IDX_W-1:0]      c_idx   [BUFFER_DEPTH];
  logic        [CNT_W-1:0]      c_rank  [BUFFER_DEPTH];
  logic        [CNT_W-1:0]      c_fwd   [BUFFER_DEPTH];
  logic                         c_in    [BUFFER_DEPTH];

  logic                         can_push;
  logic                         out_push;
  logic                         issue_due;
  logic                         retire_ok;
  logic        [TIME_BITS-1:0]  ref_time;
  logic        [CNT_W-1:0]      lo_rank, hi_rank, next_pos;
  logic signed [VALUE_BITS:0]   mid_sum;
  logic                         trunc_now;
  result_t                      new_res;
  logic                         last_step;

  genvar g;
  generate
    for (g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
      twrm_cell #(
        .TIME_BITS (TIME_BITS),
        .VALUE_BITS(VALUE_BITS),
        .IDX_W     (IDX_W),
        .CELL_POS  (g)
      ) u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .pend_time_i   (pend_time_q),
        .reach_back_i  (wb_q),
        .reach_ahead_i (wa_q),
        .nb_time_i     (c_time[(g + 1) % BUFFER_DEPTH]),
        .nb_value_i    (c_value[(g + 1) % BUFFER_DEPTH]),
        .nb_idx_i      (c_idx[(g + 1) % BUFFER_DEPTH]),
        .nb_rank_i     (c_fwd[(g + 1) % BUFFER_DEPTH]),
        .head_value_i  (c_value[0]),
        .head_idx_i    (c_idx[0]),
        .head_in_i     (c_in[0]),
        .new_time_i    (in_time_q),
        .new_value_i   (in_value_q),
        .time_o        (c_time[g]),
        .value_o       (c_value[g]),
        .idx_o         (c_idx[g]),
        .rank_o        (c_rank[g]),
        .rank_fwd_o    (c_fwd[g]),
        .in_win_o      (c_in[g])
      );
    end
  endgenerate

  always_comb begin
    ctrl.stored = stored_q;
    ctrl.wr_pos = stored_q;
    ctrl.op     = CELL_HOLD;
    case (state_q)
      S_START: ctrl.op = CELL_START;
      S_PASS1: ctrl.op = CELL_RANK;
      S_PASS2: ctrl.op = CELL_ROTATE;
      S_RETIRE: if (retire_ok) ctrl.op = CELL_SHIFT;
      S_DROP: if (stored_q >= CNT_W'(BUFFER_DEPTH)) ctrl.op = CELL_SHIFT;
      S_WRITE: ctrl.op = CELL_WRITE;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  always_comb begin
    can_push  = !out_v_q || !out_stall_i;
    out_push  = can_push && held_v_q && ((state_q == S_EMIT) || (state_q == S_FIN));
    issue_due = (pend_q != '0) && (in_time_q > pend_time_q) &&
                (CMP_W'(in_time_q - pend_time_q) > CMP_W'(wa_q));
    ref_time  = (pend_q != '0) ? pend_time_q : in_time_q;
    retire_ok = (stored_q > pend_q) && (c_time[0] <= ref_time) &&
                (CMP_W'(ref_time - c_time[0]) >= CMP_W'(wb_q));
    lo_rank   = (win_cnt_q - CNT_W'(1)) >> 1;
    hi_rank   = win_cnt_q >> 1;
    next_pos  = stored_q - pend_q + CNT_W'(1);
    last_step = step_q == IDX_W'(BUFFER_DEPTH - 1);
    mid_sum   = {lo_q[VALUE_BITS-1], lo_q} + {hi_q[VALUE_BITS-1], hi_q};
    trunc_now = force_q || (ovf_q && ((horizon_q > pend_time_q) ||
                (CMP_W'(pend_time_q - horizon_q) < CMP_W'(wb_q))));
    new_res.rtime = pend_time_q;
    new_res.med   = (win_cnt_q == '0) ? '0 : mid_sum[VALUE_BITS:1];
    new_res.cnt   = win_cnt_q;
    new_res.empty = win_cnt_q == '0;
    new_res.trunc = trunc_now;
    new_res.oerr  = 1'b0;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= CFG_W'(1);
      wa_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_REACH_BACK) begin
        wb_q <= cfg_data_i;
      end else if (cfg_index_i == REG_REACH_AHEAD) begin
        wa_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      stored_q    <= '0;
      pend_q      <= '0;
      prev_time_q <= '0;
      horizon_q   <= '0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      held_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (out_push) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_time_q  <= obs_time_i;
            in_value_q <= obs_value_i;
            in_eos_q   <= end_of_series_i;
            if (seen_q && (obs_time_i < prev_time_q)) begin
              held_q   <= '{rtime: obs_time_i, med: '0, cnt: '0, empty: 1'b0,
                            trunc: 1'b0, oerr: 1'b1};
              held_v_q <= 1'b1;
              state_q  <= end_of_series_i ? S_FLUSH : S_FIN;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (issue_due) begin
            force_q <= 1'b0;
            ret_q   <= S_CHECK;
            state_q <= S_START;
          end else begin
            state_q <= S_RETIRE;
          end
        end
        S_RETIRE: begin
          if (retire_ok) begin
            stored_q <= stored_q - CNT_W'(1);
          end else begin
            state_q <= S_DROP;
          end
        end
        S_DROP: begin
          if (stored_q >= CNT_W'(BUFFER_DEPTH)) begin
            horizon_q <= c_time[0];
            ovf_q     <= 1'b1;
            stored_q  <= stored_q - CNT_W'(1);
          end
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          stored_q    <= stored_q + CNT_W'(1);
          pend_q      <= pend_q + CNT_W'(1);
          if (pend_q == '0) begin
            pend_time_q <= in_time_q;
          end
          prev_time_q <= in_time_q;
          seen_q      <= 1'b1;
          state_q     <= S_AFTER;
        end
        S_AFTER: begin
          if (!in_eos_q && (pend_q >= CNT_W'(BUFFER_DEPTH))) begin
            force_q <= 1'b1;
            ret_q   <= S_FIN;
            state_q <= S_START;
          end else begin
            state_q <= in_eos_q ? S_FLUSH : S_FIN;
          end
        end
        S_FLUSH: begin
          if (pend_q != '0) begin
            force_q <= 1'b0;
            ret_q   <= S_FLUSH;
            state_q <= S_START;
          end else begin
            stored_q    <= '0;
            prev_time_q <= '0;
            seen_q      <= 1'b0;
            horizon_q   <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_FIN;
          end
        end
        S_START: begin
          win_cnt_q <= '0;
          step_q    <= '0;
          state_q   <= S_PASS1;
        end
        S_PASS1: begin
          win_cnt_q <= win_cnt_q + CNT_W'(c_in[0]);
          if (CNT_W'(c_idx[0]) == next_pos) begin
            next_pt_q <= c_time[0];
          end
          if (last_step) begin
            step_q  <= '0;
            state_q <= S_PASS2;
          end else begin
            step_q <= step_q + IDX_W'(1);
          end
        end
        S_PASS2: begin
          if (c_in[0] && (c_rank[0] == lo_rank)) begin
            lo_q <= c_value[0];
          end
          if (c_in[0] && (c_rank[0] == hi_rank)) begin
            hi_q <= c_value[0];
          end
          step_q <= step_q + IDX_W'(1);
          if (last_step) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!held_v_q || can_push) begin
            if (held_v_q) begin
              out_q      <= held_q;
              out_last_q <= 1'b0;
            end
            held_q      <= new_res;
            held_v_q    <= 1'b1;
            pend_q      <= pend_q - CNT_W'(1);
            pend_time_q <= next_pt_q;
            state_q     <= ret_q;
          end
        end
        S_FIN: begin
          if (!held_v_q) begin
            state_q <= S_IDLE;
          end else if (can_push) begin
            out_q      <= held_q;
            out_last_q <= 1'b1;
            held_v_q   <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_v_q;
  assign result_time_o  = out_q.rtime;
  assign median_value_o = out_q.med;
  assign window_count_o = out_q.cnt;
  assign empty_window_o = out_q.empty;
  assign truncated_o    = out_q.trunc;
  assign order_error_o  = out_q.oerr;
  assign last_in_run_o  = out_last_q;

  `TWRM_ASSERT(a_pend_le_stored, pend_q <= stored_q, "more pending than stored")
  `TWRM_ASSERT(a_stored_le_depth, stored_q <= CNT_W'(BUFFER_DEPTH), "count over depth")
  `TWRM_ASSERT(a_idle_nothing_held, (state_q == S_IDLE) |-> !held_v_q, "held while idle")
  `TWRM_ASSERT(a_idle_pend_room, (state_q == S_IDLE) |-> (pend_q < CNT_W'(BUFFER_DEPTH)), "full")

endmodule
